>>> sv/sjvr_pkg.sv
`default_nettype none

package sjvr_pkg;

   localparam int MAX_SERVOS     = 5;
   localparam int NUM_SERVOS_DEF = 5;
   localparam int CENTER_US_DEF  = 1500;

   localparam int STEP_W    = 8;
   localparam int PULSE_W   = 12;
   localparam int TICK_W    = 8;
   localparam int MAX_STEPS_W = STEP_W * MAX_SERVOS;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = MAX_STEPS_W;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ACCEL_STEP    = csr_index_type'(0);
   localparam csr_index_type CSR_DECEL_STEP    = csr_index_type'(1);
   localparam csr_index_type CSR_PULSE_MIN     = csr_index_type'(2);
   localparam csr_index_type CSR_PULSE_MAX     = csr_index_type'(3);
   localparam csr_index_type CSR_TIMEOUT_TICKS = csr_index_type'(4);
   localparam csr_index_type CSR_MAX_STEPS     = csr_index_type'(5);

   typedef enum logic [1:0] {
      ST_AT_TARGET,
      ST_ACCEL,
      ST_AT_MAX,
      ST_DECEL
   } status_type;

   typedef struct packed {
      logic [STEP_W-1:0]      accel_step;
      logic [STEP_W-1:0]      decel_step;
      logic [PULSE_W-1:0]     pulse_min;
      logic [PULSE_W-1:0]     pulse_max;
      logic [TICK_W-1:0]      timeout_ticks;
      logic [MAX_STEPS_W-1:0] max_steps;
   } cfg_type;

endpackage

`default_nettype wire

>>> sv/servo_jog_velocity_ramp_core.sv
// Jog velocity ramp for up to five servos, one control tick per request transfer.
// Request channel (req_*): one transfer per tick, optionally carrying a new
// command with an active bit and a direction bit per servo.
// Response channel (rsp_*): one transfer per request with all five pulse widths,
// a mask of the pulses that changed on this tick, and the command timeout flag.
// CSR channel (csr_*): register writes by index, always ready; write only while
// no request is in flight.
// The response of a request taken at a clock edge is valid in the cycle after that
// edge. Throughput is one request per cycle while the receiver does not stall, set by
// the single register stage that holds the per-servo ramp state and the response.
// A request is taken when the response register is empty or is being drained
// in the same cycle; while the receiver stalls a held response, req_stall is high.
// Reset clears the held command, the timeout counter and the ramp state, puts
// every pulse at the center value and loads the register defaults.
`default_nettype none

module servo_jog_velocity_ramp_core #(
   parameter int NUM_SERVOS = sjvr_pkg::NUM_SERVOS_DEF,
   parameter int CENTER_US  = sjvr_pkg::CENTER_US_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_new_command,
   input  wire logic [4:0]                          req_request_active_mask,
   input  wire logic [4:0]                          req_request_direction_mask,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [sjvr_pkg::PULSE_W-1:0]             rsp_pulse_base,
   output logic [sjvr_pkg::PULSE_W-1:0]             rsp_pulse_shoulder,
   output logic [sjvr_pkg::PULSE_W-1:0]             rsp_pulse_forearm,
   output logic [sjvr_pkg::PULSE_W-1:0]             rsp_pulse_wrist,
   output logic [sjvr_pkg::PULSE_W-1:0]             rsp_pulse_gripper,
   output logic [4:0]                               rsp_write_mask,
   output logic                                     rsp_timed_out,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sjvr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sjvr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sjvr_pkg::*;

   localparam logic [PULSE_W-1:0] CENTER = PULSE_W'(CENTER_US);

   cfg_type cfg_ff;

   logic [MAX_SERVOS-1:0] held_active_ff;
   logic [MAX_SERVOS-1:0] held_direction_ff;
   logic [TICK_W-1:0]     ticks_ff;
   logic [TICK_W-1:0]     ticks_eff;
   logic [TICK_W-1:0]     ticks_in;
   logic [MAX_SERVOS-1:0] held_active_in;
   logic [MAX_SERVOS-1:0] held_direction_in;
   logic                  timeout;
   logic [MAX_SERVOS-1:0] act;
   logic [MAX_SERVOS-1:0] dir;

   status_type            status_ff   [MAX_SERVOS];
   status_type            status_in   [MAX_SERVOS];
   logic [MAX_SERVOS-1:0] moving_ff;
   logic [MAX_SERVOS-1:0] moving_in;
   logic [MAX_SERVOS-1:0] mdir_ff;
   logic [MAX_SERVOS-1:0] mdir_in;
   logic [STEP_W-1:0]     step_ff     [MAX_SERVOS];
   logic [STEP_W-1:0]     step_in     [MAX_SERVOS];
   logic [PULSE_W-1:0]    pulse_ff    [MAX_SERVOS];
   logic [PULSE_W-1:0]    pulse_in    [MAX_SERVOS];
   logic [MAX_SERVOS-1:0] wmask_in;

   logic                  rsp_valid_ff;
   logic [MAX_SERVOS-1:0] wmask_ff;
   logic                  timed_out_ff;
   logic                  req_take;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      held_active_in    = held_active_ff;
      held_direction_in = held_direction_ff;
      ticks_eff         = ticks_ff;
      if (req_new_command) begin
         held_active_in    = req_request_active_mask;
         held_direction_in = req_request_direction_mask;
         ticks_eff         = '0;
      end
      timeout  = ticks_eff >= cfg_ff.timeout_ticks;
      ticks_in = (ticks_eff == '1) ? ticks_eff : ticks_eff + TICK_W'(1);
      act      = timeout ? '0 : held_active_in;
      dir      = timeout ? '0 : held_direction_in;
   end

   for (genvar i = 0; i < MAX_SERVOS; i++) begin : g_servo
      if (i < NUM_SERVOS) begin : g_live
         status_type           st;
         logic                 mf;
         logic                 md;
         logic [STEP_W:0]      stp;
         logic [STEP_W:0]      mx;
         logic [PULSE_W-1:0]   p;
         logic [PULSE_W:0]     sum;
         logic [PULSE_W:0]     lim;

         always_comb begin
            st  = status_ff[i];
            mf  = moving_ff[i];
            md  = mdir_ff[i];
            stp = {1'b0, step_ff[i]};
            mx  = {1'b0, cfg_ff.max_steps[STEP_W*i +: STEP_W]};
            p   = pulse_ff[i];

            if (!act[i]) begin
               if (mf) begin
                  st = ST_DECEL;
               end
            end else if (!mf) begin
               mf = 1'b1;
               md = dir[i];
               st = ST_ACCEL;
            end else if (md != dir[i]) begin
               st = ST_DECEL;
            end else if (st == ST_AT_TARGET) begin
               st = ST_ACCEL;
            end

            unique case (st)
               ST_DECEL: begin
                  if (stp > {1'b0, cfg_ff.decel_step}) begin
                     stp = stp - {1'b0, cfg_ff.decel_step};
                  end else begin
                     stp = '0;
                  end
                  if (stp == '0) begin
                     if (act[i] && md != dir[i]) begin
                        md = dir[i];
                        mf = 1'b1;
                        st = ST_ACCEL;
                     end else begin
                        mf = 1'b0;
                        st = ST_AT_TARGET;
                     end
                  end
               end
               ST_ACCEL: begin
                  mf = 1'b1;
                  if (stp < mx) begin
                     stp = stp + {1'b0, cfg_ff.accel_step};
                     if (stp > mx) begin
                        stp = mx;
                     end
                  end
                  if (stp >= mx) begin
                     st = ST_AT_MAX;
                  end
               end
               ST_AT_MAX: begin
                  mf  = 1'b1;
                  stp = mx;
               end
               ST_AT_TARGET: begin
                  mf  = 1'b0;
                  stp = '0;
               end
            endcase

            sum = {1'b0, p} + {{(PULSE_W-STEP_W){1'b0}}, stp};
            lim = {1'b0, cfg_ff.pulse_min} + {{(PULSE_W-STEP_W){1'b0}}, stp};
            if (stp != '0) begin
               if (md) begin
                  if (p < cfg_ff.pulse_max) begin
                     if (sum > {1'b0, cfg_ff.pulse_max}) begin
                        p = cfg_ff.pulse_max;
                     end else begin
                        p = sum[PULSE_W-1:0];
                     end
                  end
               end else begin
                  if ({1'b0, p} > lim) begin
                     p = p - {{(PULSE_W-STEP_W){1'b0}}, stp[STEP_W-1:0]};
                  end else begin
                     p = cfg_ff.pulse_min;
                  end
               end
            end

            if (p == cfg_ff.pulse_min || p == cfg_ff.pulse_max) begin
               stp = '0;
               mf  = 1'b0;
               st  = ST_AT_TARGET;
            end
         end

         assign status_in[i] = st;
         assign moving_in[i] = mf;
         assign mdir_in[i]   = md;
         assign step_in[i]   = stp[STEP_W-1:0];
         assign pulse_in[i]  = p;
         assign wmask_in[i]  = p != pulse_ff[i];
      end else begin : g_absent
         assign status_in[i] = ST_AT_TARGET;
         assign moving_in[i] = 1'b0;
         assign mdir_in[i]   = 1'b0;
         assign step_in[i]   = '0;
         assign pulse_in[i]  = CENTER;
         assign wmask_in[i]  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_step    <= STEP_W'(2);
         cfg_ff.decel_step    <= STEP_W'(4);
         cfg_ff.pulse_min     <= PULSE_W'(500);
         cfg_ff.pulse_max     <= PULSE_W'(2500);
         cfg_ff.timeout_ticks <= TICK_W'(3);
         cfg_ff.max_steps     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ACCEL_STEP:    cfg_ff.accel_step    <= csr_data[STEP_W-1:0];
            CSR_DECEL_STEP:    cfg_ff.decel_step    <= csr_data[STEP_W-1:0];
            CSR_PULSE_MIN:     cfg_ff.pulse_min     <= csr_data[PULSE_W-1:0];
            CSR_PULSE_MAX:     cfg_ff.pulse_max     <= csr_data[PULSE_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_data[TICK_W-1:0];
            CSR_MAX_STEPS:     cfg_ff.max_steps     <= csr_data[MAX_STEPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_active_ff    <= '0;
         held_direction_ff <= '0;
         ticks_ff          <= '0;
         moving_ff         <= '0;
         mdir_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         for (int i = 0; i < MAX_SERVOS; i++) begin
            status_ff[i] <= ST_AT_TARGET;
            step_ff[i]   <= '0;
            pulse_ff[i]  <= CENTER;
         end
      end else begin
         if (req_take) begin
            held_active_ff    <= held_active_in;
            held_direction_ff <= held_direction_in;
            ticks_ff          <= ticks_in;
            moving_ff         <= moving_in;
            mdir_ff           <= mdir_in;
            for (int i = 0; i < MAX_SERVOS; i++) begin
               status_ff[i] <= status_in[i];
               step_ff[i]   <= step_in[i];
               pulse_ff[i]  <= pulse_in[i];
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         wmask_ff     <= wmask_in;
         timed_out_ff <= timeout;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pulse_base     = pulse_ff[0];
   assign rsp_pulse_shoulder = pulse_ff[1];
   assign rsp_pulse_forearm  = pulse_ff[2];
   assign rsp_pulse_wrist    = pulse_ff[3];
   assign rsp_pulse_gripper  = pulse_ff[4];
   assign rsp_write_mask     = wmask_ff;
   assign rsp_timed_out      = timed_out_ff;

   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("request transfer did not produce a response");

   a_fresh_command_not_timed_out: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_new_command && cfg_ff.timeout_ticks != '0) |=> !rsp_timed_out)
      else $error("fresh command reported as timed out");

   a_absent_servo_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_mask >> NUM_SERVOS) == '0)
      else $error("write mask set for an absent servo");

   a_stopped_has_no_step: assert property (@(posedge clock) disable iff (reset)
      (status_ff[0] == ST_AT_TARGET) |-> (step_ff[0] == '0 && !moving_ff[0]))
      else $error("servo at target with a nonzero step or moving flag");

endmodule

`default_nettype wire
